>>> rtl/core/trap_entry_unit_core_defines.svh
// Assertion helpers shared by the trap entry unit. Each expects clk and rst_n in scope.
`ifndef TRAP_ENTRY_UNIT_CORE_DEFINES_SVH
`define TRAP_ENTRY_UNIT_CORE_DEFINES_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define TEU_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define TEU_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/teu_pkg.sv
package teu_pkg;

    localparam int XLEN      = 64;
    localparam int CAUSE_W   = 6;
    localparam int MODE_W    = 2;
    localparam int CFG_IDX_W = 2;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DELEG_MASK = 2'd0,
        CFG_SUPV_VEC   = 2'd1,
        CFG_MACH_VEC   = 2'd2
    } cfg_idx_t;

    typedef logic [MODE_W-1:0] mode_t;

    localparam mode_t MODE_SUPERVISOR = 2'd1;
    localparam mode_t MODE_MACHINE    = 2'd3;

    // Status word bit positions.
    localparam int SIE_POS      = 1;
    localparam int MIE_POS      = 3;
    localparam int SPIE_POS     = 5;
    localparam int MPIE_POS     = 7;
    localparam int SPP_POS      = 8;
    localparam int MPP_LO_POS   = 11;
    localparam int MPP_HI_POS   = 12;
    localparam int INT_FLAG_POS = XLEN - 1;

endpackage

>>> rtl/core/teu_if.sv
interface teu_req_if;
    import teu_pkg::*;

    logic                valid;
    logic                ready;
    logic [XLEN-1:0]     trap_pc;
    logic [CAUSE_W-1:0]  cause_code;
    logic [XLEN-1:0]     trap_value;
    logic                interrupt;
    logic [MODE_W-1:0]   current_mode;
    logic [XLEN-1:0]     machine_status_in;
    logic [XLEN-1:0]     supervisor_status_in;

    modport source (
        output valid, trap_pc, cause_code, trap_value, interrupt, current_mode,
               machine_status_in, supervisor_status_in,
        input  ready
    );
    modport sink (
        input  valid, trap_pc, cause_code, trap_value, interrupt, current_mode,
               machine_status_in, supervisor_status_in,
        output ready
    );
endinterface

interface teu_rsp_if;
    import teu_pkg::*;

    logic                valid;
    logic                ready;
    logic                to_supervisor;
    logic [MODE_W-1:0]   new_mode;
    logic [XLEN-1:0]     next_pc;
    logic [XLEN-1:0]     saved_pc;
    logic [XLEN-1:0]     cause_word;
    logic [XLEN-1:0]     saved_trap_value;
    logic [XLEN-1:0]     new_status;

    modport source (
        output valid, to_supervisor, new_mode, next_pc, saved_pc, cause_word,
               saved_trap_value, new_status,
        input  ready
    );
    modport sink (
        input  valid, to_supervisor, new_mode, next_pc, saved_pc, cause_word,
               saved_trap_value, new_status,
        output ready
    );
endinterface

interface teu_cfg_if;
    import teu_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [XLEN-1:0]       data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

>>> rtl/core/trap_entry_unit_core.sv
// Trap entry unit: one trap request in, one result out. A request is registered on
// acceptance, the delegation decision, handler address and status update are computed
// from that register, and the result is held in an output register until taken. A new
// request can be accepted every cycle as long as the output side keeps taking results.
// The delegation mask and both vector bases reset to zero and are written through the
// configuration channel, which is always ready; they should only be changed while no
// request is in flight.
`include "trap_entry_unit_core_defines.svh"

module trap_entry_unit_core (
    input  logic        clk,
    input  logic        rst_n,
    teu_req_if.sink     req,
    teu_rsp_if.source   rsp,
    teu_cfg_if.sink     cfg
);
    import teu_pkg::*;

    logic [XLEN-1:0]    deleg_mask_reg;
    logic [XLEN-1:0]    supv_vec_reg;
    logic [XLEN-1:0]    mach_vec_reg;

    logic               in_valid_reg;
    logic [XLEN-1:0]    in_pc_reg;
    logic [CAUSE_W-1:0] in_cause_reg;
    logic [XLEN-1:0]    in_tval_reg;
    logic               in_intr_reg;
    logic [MODE_W-1:0]  in_mode_reg;
    logic [XLEN-1:0]    in_mstatus_reg;
    logic [XLEN-1:0]    in_sstatus_reg;

    logic               out_valid_reg;
    logic               out_to_supv_reg;
    logic [MODE_W-1:0]  out_mode_reg;
    logic [XLEN-1:0]    out_npc_reg;
    logic [XLEN-1:0]    out_pc_reg;
    logic [XLEN-1:0]    out_cause_reg;
    logic [XLEN-1:0]    out_tval_reg;
    logic [XLEN-1:0]    out_status_reg;

    logic               out_free;
    logic               in_take;
    logic               deleg;
    logic [XLEN-1:0]    vec;
    logic [XLEN-1:0]    base;
    logic [XLEN-1:0]    npc_next;
    logic [XLEN-1:0]    status_next;
    logic [XLEN-1:0]    cause_next;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            deleg_mask_reg <= '0;
            supv_vec_reg   <= '0;
            mach_vec_reg   <= '0;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                CFG_DELEG_MASK: deleg_mask_reg <= cfg.data;
                CFG_SUPV_VEC:   supv_vec_reg   <= cfg.data;
                CFG_MACH_VEC:   mach_vec_reg   <= cfg.data;
                default:        ;
            endcase
        end
    end

    // The output register frees up either when empty or when its result is taken.
    assign out_free  = !out_valid_reg || rsp.ready;
    assign req.ready = !in_valid_reg || out_free;
    assign in_take   = req.valid && req.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (req.ready)
        begin
            in_valid_reg <= req.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_pc_reg      <= req.trap_pc;
            in_cause_reg   <= req.cause_code;
            in_tval_reg    <= req.trap_value;
            in_intr_reg    <= req.interrupt;
            in_mode_reg    <= req.current_mode;
            in_mstatus_reg <= req.machine_status_in;
            in_sstatus_reg <= req.supervisor_status_in;
        end
    end

    // Only synchronous exceptions from user or supervisor mode can be delegated.
    assign deleg = !in_intr_reg && !in_mode_reg[1] && deleg_mask_reg[in_cause_reg];
    assign vec   = deleg ? supv_vec_reg : mach_vec_reg;
    assign base  = {vec[XLEN-1:2], 2'b00};

    always_comb
    begin
        if (vec[0] && in_intr_reg)
        begin
            npc_next = base + {{(XLEN-CAUSE_W-2){1'b0}}, in_cause_reg, 2'b00};
        end
        else
        begin
            npc_next = base;
        end
    end

    always_comb
    begin
        if (deleg)
        begin
            status_next           = in_sstatus_reg;
            status_next[SPP_POS]  = in_mode_reg[0];
            status_next[SPIE_POS] = in_sstatus_reg[SIE_POS];
            status_next[SIE_POS]  = 1'b0;
        end
        else
        begin
            status_next                        = in_mstatus_reg;
            status_next[MPP_HI_POS:MPP_LO_POS] = in_mode_reg;
            status_next[MPIE_POS]              = in_mstatus_reg[MIE_POS];
            status_next[MIE_POS]               = 1'b0;
        end
    end

    always_comb
    begin
        cause_next               = {{(XLEN-CAUSE_W){1'b0}}, in_cause_reg};
        cause_next[INT_FLAG_POS] = in_intr_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free && in_valid_reg)
        begin
            out_to_supv_reg <= deleg;
            out_mode_reg    <= deleg ? MODE_SUPERVISOR : MODE_MACHINE;
            out_npc_reg     <= npc_next;
            out_pc_reg      <= in_pc_reg;
            out_cause_reg   <= cause_next;
            out_tval_reg    <= in_tval_reg;
            out_status_reg  <= status_next;
        end
    end

    assign rsp.valid            = out_valid_reg;
    assign rsp.to_supervisor    = out_to_supv_reg;
    assign rsp.new_mode         = out_mode_reg;
    assign rsp.next_pc          = out_npc_reg;
    assign rsp.saved_pc         = out_pc_reg;
    assign rsp.cause_word       = out_cause_reg;
    assign rsp.saved_trap_value = out_tval_reg;
    assign rsp.new_status       = out_status_reg;

    `TEU_ASSERT_SAME(a_deleg_is_exception, out_valid_reg && out_to_supv_reg,
        out_mode_reg == MODE_SUPERVISOR && !out_cause_reg[INT_FLAG_POS],
        "delegated result is not a supervisor exception")

    `TEU_ASSERT_SAME(a_no_accept_when_full, in_take,
        !(in_valid_reg && out_valid_reg && !rsp.ready),
        "request accepted while both stages are blocked")

    `TEU_ASSERT_NEXT(a_stage_advances, in_valid_reg && out_free,
        out_valid_reg,
        "registered request did not reach the output")

endmodule

>>> tb/sv/tb_top.sv
module tb_top;
    import teu_pkg::*;

    localparam mode_t MODE_USER     = 2'd0;
    localparam mode_t MODE_RESERVED = 2'd2;
    localparam logic [XLEN-1:0] ALL_ONES = '1;

    typedef struct {
        logic [XLEN-1:0]    pc;
        logic [CAUSE_W-1:0] cause;
        logic [XLEN-1:0]    tval;
        logic               intr;
        mode_t              mode;
        logic [XLEN-1:0]    mstatus;
        logic [XLEN-1:0]    sstatus;
    } trap_req_t;

    typedef struct {
        logic            to_sup;
        mode_t           mode;
        logic [XLEN-1:0] next_pc;
        logic [XLEN-1:0] saved_pc;
        logic [XLEN-1:0] cause_word;
        logic [XLEN-1:0] saved_tval;
        logic [XLEN-1:0] status;
    } trap_rsp_t;

    class trap_scoreboard;
        logic [XLEN-1:0] deleg_mask;
        logic [XLEN-1:0] supv_vec;
        logic [XLEN-1:0] mach_vec;
        trap_rsp_t       pending_entries[$];
        int              errors;

        function new();
            deleg_mask = '0;
            supv_vec   = '0;
            mach_vec   = '0;
            errors     = 0;
        endfunction

        function void write_reg(cfg_idx_t idx, logic [XLEN-1:0] value);
            case (idx)
                CFG_DELEG_MASK: deleg_mask = value;
                CFG_SUPV_VEC:   supv_vec   = value;
                CFG_MACH_VEC:   mach_vec   = value;
                default: ;
            endcase
        endfunction

        function trap_rsp_t trap_entry(trap_req_t r);
            trap_rsp_t       e;
            logic [XLEN-1:0] vec;
            logic [XLEN-1:0] st;
            // Only synchronous exceptions from user or supervisor can be delegated.
            e.to_sup = !r.intr && (r.mode == MODE_USER || r.mode == MODE_SUPERVISOR)
                       && deleg_mask[r.cause];
            if (e.to_sup)
            begin
                st = r.sstatus;
                st[SPP_POS]  = r.mode[0];
                st[SPIE_POS] = st[SIE_POS];
                st[SIE_POS]  = 1'b0;
                vec    = supv_vec;
                e.mode = MODE_SUPERVISOR;
            end
            else
            begin
                st = r.mstatus;
                st[MPP_HI_POS:MPP_LO_POS] = r.mode;
                st[MPIE_POS] = st[MIE_POS];
                st[MIE_POS]  = 1'b0;
                vec    = mach_vec;
                e.mode = MODE_MACHINE;
            end
            e.next_pc = {vec[XLEN-1:2], 2'b00};
            // The vector offset applies to interrupts only and wraps at 64 bits.
            if (vec[0] && r.intr)
                e.next_pc = e.next_pc + {{(XLEN-CAUSE_W-2){1'b0}}, r.cause, 2'b00};
            e.cause_word = '0;
            e.cause_word[CAUSE_W-1:0]    = r.cause;
            e.cause_word[INT_FLAG_POS]   = r.intr;
            e.saved_pc   = r.pc;
            e.saved_tval = r.tval;
            e.status     = st;
            return e;
        endfunction

        function void note_request(trap_req_t r);
            pending_entries.push_back(trap_entry(r));
        endfunction

        function bit field_ok(string name, logic [XLEN-1:0] exp, logic [XLEN-1:0] act);
            if (act !== exp)
            begin
                $error("%s mismatch: expected %h, got %h", name, exp, act);
                return 1'b0;
            end
            return 1'b1;
        endfunction

        function void check_result(trap_rsp_t got);
            trap_rsp_t e;
            bit        ok;
            if (pending_entries.size() == 0)
            begin
                $error("trap result with no request outstanding");
                errors++;
                return;
            end
            e  = pending_entries.pop_front();
            ok = field_ok("to_supervisor", XLEN'(e.to_sup), XLEN'(got.to_sup))
               & field_ok("new_mode", XLEN'(e.mode), XLEN'(got.mode))
               & field_ok("next_pc", e.next_pc, got.next_pc)
               & field_ok("saved_pc", e.saved_pc, got.saved_pc)
               & field_ok("cause_word", e.cause_word, got.cause_word)
               & field_ok("saved_trap_value", e.saved_tval, got.saved_tval)
               & field_ok("new_status", e.status, got.status);
            if (!ok)
                errors++;
        endfunction
    endclass

    logic clk;
    logic rst_n;
    bit   idle_on;
    bit   hold_results;

    teu_req_if req_ch();
    teu_rsp_if rsp_ch();
    teu_cfg_if cfg_ch();

    trap_entry_unit_core u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch.sink),
        .rsp   (rsp_ch.source),
        .cfg   (cfg_ch.sink)
    );

    trap_scoreboard sb = new();

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #20_000_000;
        $display("== FAIL ==");
        $finish;
    end

    function automatic int pick_gap(bit enabled);
        int r;
        if (!enabled)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [XLEN-1:0] random_word();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return ALL_ONES;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic trap_req_t make_trap(logic [XLEN-1:0] pc, logic [CAUSE_W-1:0] cause,
                                            logic [XLEN-1:0] tval, logic intr, mode_t mode,
                                            logic [XLEN-1:0] mst, logic [XLEN-1:0] sst);
        trap_req_t r;
        r.pc      = pc;
        r.cause   = cause;
        r.tval    = tval;
        r.intr    = intr;
        r.mode    = mode;
        r.mstatus = mst;
        r.sstatus = sst;
        return r;
    endfunction

    function automatic trap_req_t random_trap();
        trap_req_t r;
        int        pick;
        r.pc   = {$urandom, $urandom};
        r.tval = random_word();
        r.intr = 1'($urandom_range(0, 1));
        pick = $urandom_range(0, 9);
        if (pick == 0)
            r.cause = '1;
        else if (pick == 1)
            r.cause = '0;
        else
            r.cause = CAUSE_W'($urandom_range(0, 63));
        pick = $urandom_range(0, 9);
        if (pick < 4)
            r.mode = MODE_USER;
        else if (pick < 7)
            r.mode = MODE_SUPERVISOR;
        else if (pick < 9)
            r.mode = MODE_MACHINE;
        else
            r.mode = MODE_RESERVED;
        r.mstatus = random_word();
        r.sstatus = random_word();
        return r;
    endfunction

    // Each request is held until accepted; the next one follows in the same step
    // when there is no gap, so valid is never dropped and raised in one step.
    task automatic send_trap(trap_req_t r, int gap);
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid                <= 1'b1;
        req_ch.trap_pc              <= r.pc;
        req_ch.cause_code           <= r.cause;
        req_ch.trap_value           <= r.tval;
        req_ch.interrupt            <= r.intr;
        req_ch.current_mode         <= r.mode;
        req_ch.machine_status_in    <= r.mstatus;
        req_ch.supervisor_status_in <= r.sstatus;
        do @(posedge clk); while (!req_ch.ready);
        sb.note_request(r);
    endtask

    task automatic write_reg(cfg_idx_t idx, logic [XLEN-1:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        do @(posedge clk); while (!cfg_ch.ready);
        sb.write_reg(idx, value);
    endtask

    task automatic program_regs(logic [XLEN-1:0] mask, logic [XLEN-1:0] svec,
                                logic [XLEN-1:0] mvec);
        write_reg(CFG_DELEG_MASK, mask);
        write_reg(CFG_SUPV_VEC, svec);
        write_reg(CFG_MACH_VEC, mvec);
        cfg_ch.valid <= 1'b0;
    endtask

    // The block holds at most two requests; drain waits until their results return.
    task automatic drain(int limit);
        int n;
        req_ch.valid <= 1'b0;
        n = 0;
        while (sb.pending_entries.size() != 0 && n < limit)
        begin
            @(posedge clk);
            n++;
        end
        repeat (4) @(posedge clk);
    endtask

    // Result side: random stalls, plus one long hold-off on request.
    initial
    begin
        int stall;
        rsp_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (hold_results)
            begin
                hold_results = 1'b0;
                rsp_ch.ready <= 1'b0;
                repeat (400) @(posedge clk);
            end
            else
            begin
                stall = pick_gap(idle_on);
                if (stall == 0)
                begin
                    rsp_ch.ready <= 1'b1;
                    @(posedge clk);
                end
                else
                begin
                    rsp_ch.ready <= 1'b0;
                    repeat (stall) @(posedge clk);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        trap_rsp_t got;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            got.to_sup     = rsp_ch.to_supervisor;
            got.mode       = rsp_ch.new_mode;
            got.next_pc    = rsp_ch.next_pc;
            got.saved_pc   = rsp_ch.saved_pc;
            got.cause_word = rsp_ch.cause_word;
            got.saved_tval = rsp_ch.saved_trap_value;
            got.status     = rsp_ch.new_status;
            sb.check_result(got);
        end
    end

    initial
    begin
        rst_n                       <= 1'b0;
        idle_on                      = 1'b0;
        hold_results                 = 1'b0;
        req_ch.valid                <= 1'b0;
        req_ch.trap_pc              <= '0;
        req_ch.cause_code           <= '0;
        req_ch.trap_value           <= '0;
        req_ch.interrupt            <= 1'b0;
        req_ch.current_mode         <= MODE_USER;
        req_ch.machine_status_in    <= '0;
        req_ch.supervisor_status_in <= '0;
        cfg_ch.valid                <= 1'b0;
        cfg_ch.index                <= CFG_DELEG_MASK;
        cfg_ch.data                 <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Registers at their reset values: nothing is delegated, no vectoring.
        send_trap(make_trap('0, 6'd0, '0, 1'b0, MODE_USER, '0, '0), 0);
        send_trap(make_trap(ALL_ONES, 6'd63, ALL_ONES, 1'b1, MODE_MACHINE,
                            ALL_ONES, ALL_ONES), 0);
        send_trap(make_trap(64'h8000_0000_0000_1000, 6'd2, 64'h13, 1'b0, MODE_RESERVED,
                            64'h8, '0), 0);
        drain(1000);

        // Everything delegable, both vectors vectored with all address bits set.
        program_regs(ALL_ONES, ALL_ONES, ALL_ONES);
        send_trap(make_trap(64'h1000, 6'd0, 64'hdead, 1'b0, MODE_USER, ALL_ONES, '0), 0);
        send_trap(make_trap(64'h2000, 6'd63, 64'hbeef, 1'b0, MODE_SUPERVISOR, '0, 64'h2), 0);
        send_trap(make_trap(64'h3000, 6'd8, '0, 1'b0, MODE_MACHINE, 64'h8, ALL_ONES), 0);
        // Vectored interrupt whose handler address wraps past the top.
        send_trap(make_trap(64'h4000, 6'd63, '0, 1'b1, MODE_USER, '0, '0), 0);
        send_trap(make_trap(64'h5000, 6'd5, 64'h1, 1'b0, MODE_RESERVED, ALL_ONES, '0), 0);
        send_trap(make_trap(64'h6000, 6'd1, 64'h2, 1'b1, MODE_SUPERVISOR, 64'h88, '0), 0);
        drain(1000);

        // Alternate mask bits, vectored supervisor base, reserved mode bits on machine.
        program_regs(64'hAAAA_AAAA_AAAA_AAAA, 64'h0000_0000_8000_1001,
                     64'h8000_0000_0000_0002);
        send_trap(make_trap(64'h7000, 6'd1, 64'h3, 1'b0, MODE_USER, '0, 64'h122), 0);
        send_trap(make_trap(64'h7004, 6'd0, 64'h4, 1'b0, MODE_USER, '0, '0), 0);
        send_trap(make_trap(64'h7008, 6'd7, 64'h5, 1'b1, MODE_SUPERVISOR, 64'h1888, '0), 0);
        send_trap(make_trap(64'h700c, 6'd3, 64'h6, 1'b0, MODE_SUPERVISOR, '0, ALL_ONES), 0);
        send_trap(make_trap(64'h7010, 6'd62, ALL_ONES, 1'b1, MODE_RESERVED, ALL_ONES, '0), 0);
        drain(1000);

        for (int phase = 0; phase < 6; phase++)
        begin
            if (phase == 4)
                program_regs('0, '0, '0);
            else
                program_regs(random_word(), random_word(), random_word());
            // One phase runs with no idling on either side.
            idle_on = (phase != 1);
            for (int i = 0; i < 200; i++)
            begin
                if (phase == 3 && i == 20)
                    hold_results = 1'b1;
                send_trap(random_trap(), pick_gap(idle_on));
            end
            drain(5000);
        end

        if (sb.pending_entries.size() != 0)
        begin
            $error("%0d trap results never arrived", sb.pending_entries.size());
            sb.errors++;
        end
        if (sb.errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

>>> files.f
+incdir+rtl/core
rtl/core/teu_pkg.sv
rtl/core/teu_if.sv
rtl/core/trap_entry_unit_core.sv
tb/sv/tb_top.sv
